### design/aes_pkg.sv
package aes_pkg;

   localparam int BlockWidth = 128;
   localparam int KeyWidth   = 256;
   localparam int WordWidth  = 64;
   localparam int IndexWidth = 3;

   localparam logic [IndexWidth-1:0] REG_KEY0 = 3'd0;
   localparam logic [IndexWidth-1:0] REG_KEY1 = 3'd1;
   localparam logic [IndexWidth-1:0] REG_KEY2 = 3'd2;
   localparam logic [IndexWidth-1:0] REG_KEY3 = 3'd3;
   localparam logic [IndexWidth-1:0] REG_KSIZE = 3'd4;
   localparam logic [IndexWidth-1:0] REG_DIR  = 3'd5;

   typedef struct packed {
      logic load;     // start a block: state = block_in ^ first round key
      logic run;      // apply one middle round
      logic last;     // apply the final round
      logic kinit;    // step the key schedule forward without touching state
      logic start_rev;// restore key register from configured key, block start
   } aes_cmd_type;

   function automatic logic [7:0] xt(input logic [7:0] x);
      xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a_in, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] a;
      p = 8'h00;
      a = a_in;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = xt(a);
      end
      gmul = p;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] b;
      logic [7:0] e;
      r = 8'h01;
      b = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = gmul(r, b);
         b = gmul(b, b);
      end
      ginv = r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      rotl8 = (x << n) | (x >> (8 - n));
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] x);
      logic [7:0] s;
      s = ginv(x);
      sbox_calc = s ^ rotl8(s, 1) ^ rotl8(s, 2) ^ rotl8(s, 3) ^ rotl8(s, 4) ^ 8'h63;
   endfunction

   function automatic logic [7:0] isbox_calc(input logic [7:0] x);
      logic [7:0] y;
      y = x ^ 8'h63;
      isbox_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6));
   endfunction

   typedef logic [7:0] sbox_array_type [256];

   function automatic sbox_array_type make_sbox(input logic inv);
      sbox_array_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
      end
      make_sbox = t;
   endfunction

   localparam sbox_array_type SBOX  = make_sbox(1'b0);
   localparam sbox_array_type ISBOX = make_sbox(1'b1);

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

### design/aes_datapath.sv
module aes_datapath (
   input  logic                      clock,
   input  aes_pkg::aes_cmd_type      cmd,
   input  logic                      decrypt,
   input  logic                      key_size,
   input  logic [aes_pkg::KeyWidth-1:0]   key,
   input  logic [aes_pkg::BlockWidth-1:0] block_in,
   output logic [aes_pkg::BlockWidth-1:0] block_out
);
   import aes_pkg::*;

   // Key register holds the 8-word window w[i-8..i-1] (256) or 4-word (128).
   logic [KeyWidth-1:0]   key_ff, key_in;
   logic [7:0]            rc_ff, rc_in;
   logic                  half_ff, half_in;  // AES-256: which half of the window is the round key
   logic [BlockWidth-1:0] state_ff, state_in;

   logic [KeyWidth-1:0] fwd_key, rev_key;
   logic [7:0]          fwd_rc, rev_rc;

   // Forward step: AES-128 advances four words, AES-256 four words (half window).
   always_comb begin
      logic [31:0] w [8];
      logic [31:0] t;
      for (int i = 0; i < 8; i++) w[i] = key_ff[KeyWidth-1-32*i -: 32];
      fwd_key = key_ff;
      fwd_rc  = rc_ff;
      if (!key_size) begin
         t = sub_word({w[3][23:0], w[3][31:24]}) ^ {rc_ff, 24'h0};
         w[0] = w[0] ^ t;
         w[1] = w[1] ^ w[0];
         w[2] = w[2] ^ w[1];
         w[3] = w[3] ^ w[2];
         fwd_key = {w[0], w[1], w[2], w[3], 128'h0};
         fwd_rc = xt(rc_ff);
      end else if (!half_ff) begin
         t = sub_word({w[7][23:0], w[7][31:24]}) ^ {rc_ff, 24'h0};
         w[0] = w[0] ^ t;
         w[1] = w[1] ^ w[0];
         w[2] = w[2] ^ w[1];
         w[3] = w[3] ^ w[2];
         fwd_key = {w[4], w[5], w[6], w[7], w[0], w[1], w[2], w[3]};
         fwd_rc = xt(rc_ff);
      end else begin
         t = sub_word(w[7]);
         w[0] = w[0] ^ t;
         w[1] = w[1] ^ w[0];
         w[2] = w[2] ^ w[1];
         w[3] = w[3] ^ w[2];
         fwd_key = {w[4], w[5], w[6], w[7], w[0], w[1], w[2], w[3]};
      end
   end

   // Reverse step: undo one forward step.
   always_comb begin
      logic [31:0] w [8];
      logic [31:0] t;
      logic [7:0]  prc;
      for (int i = 0; i < 8; i++) w[i] = key_ff[KeyWidth-1-32*i -: 32];
      rev_key = key_ff;
      // previous rcon: inverse of xtime
      prc = rc_ff[0] ? ({1'b0, rc_ff[7:1]} ^ 8'h8d) : {1'b0, rc_ff[7:1]};
      rev_rc = rc_ff;
      if (!key_size) begin
         w[3] = w[3] ^ w[2];
         w[2] = w[2] ^ w[1];
         w[1] = w[1] ^ w[0];
         t = sub_word({w[3][23:0], w[3][31:24]}) ^ {prc, 24'h0};
         w[0] = w[0] ^ t;
         rev_key = {w[0], w[1], w[2], w[3], 128'h0};
         rev_rc = prc;
      end else if (half_ff) begin
         // last step used rcon: window is {A, B} with B newest
         w[7] = w[7] ^ w[6];
         w[6] = w[6] ^ w[5];
         w[5] = w[5] ^ w[4];
         t = sub_word({w[3][23:0], w[3][31:24]}) ^ {prc, 24'h0};
         w[4] = w[4] ^ t;
         rev_key = {w[4], w[5], w[6], w[7], w[0], w[1], w[2], w[3]};
         rev_rc = prc;
      end else begin
         w[7] = w[7] ^ w[6];
         w[6] = w[6] ^ w[5];
         w[5] = w[5] ^ w[4];
         t = sub_word(w[3]);
         w[4] = w[4] ^ t;
         rev_key = {w[4], w[5], w[6], w[7], w[0], w[1], w[2], w[3]};
      end
   end

   // Round key: oldest four words of the window; the AES-256 decrypt load
   // starts from the newest half, where the key walk leaves the final round key.
   logic [BlockWidth-1:0] rk_cur, rk_next;
   assign rk_cur  = (key_size && decrypt) ? key_ff[127:0] : key_ff[255:128];
   assign rk_next = fwd_key[255:128];

   // Round functions. Byte b of block at bits [127-8b -: 8]; byte 4c+r.
   logic [BlockWidth-1:0] enc_mid, enc_fin, dec_mid, dec_fin;
   always_comb begin
      logic [7:0] s [16];
      logic [7:0] u [16];
      logic [7:0] m [16];
      logic [7:0] x [16];
      logic [7:0] v [16];
      for (int i = 0; i < 16; i++) s[i] = state_ff[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            u[4*c+r] = SBOX[s[4*((c+r)&3)+r]];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            m[4*c+r] = xt(u[4*c+r]) ^ xt(u[4*c+((r+1)&3)]) ^ u[4*c+((r+1)&3)]
                     ^ u[4*c+((r+2)&3)] ^ u[4*c+((r+3)&3)];
      for (int i = 0; i < 16; i++) begin
         enc_mid[127-8*i -: 8] = m[i] ^ rk_next[127-8*i -: 8];
         enc_fin[127-8*i -: 8] = u[i] ^ rk_next[127-8*i -: 8];
      end
      // decrypt: inv shift, inv sub, add key (rev), inv mix
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            x[4*c+r] = ISBOX[s[4*((c-r+4)&3)+r]];
      for (int i = 0; i < 16; i++) begin
         x[i] = x[i] ^ (key_size ? rev_key[127-8*i -: 8] : rev_key[255-8*i -: 8]);
         dec_fin[127-8*i -: 8] = x[i];
      end
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            v[4*c+r] = gmul(8'd14, x[4*c+r]) ^ gmul(8'd11, x[4*c+((r+1)&3)])
                     ^ gmul(8'd13, x[4*c+((r+2)&3)]) ^ gmul(8'd9, x[4*c+((r+3)&3)]);
      for (int i = 0; i < 16; i++) dec_mid[127-8*i -: 8] = v[i];
   end

   always_comb begin
      key_in   = key_ff;
      rc_in    = rc_ff;
      half_in  = half_ff;
      state_in = state_ff;
      if (cmd.start_rev) begin
         key_in  = key_size ? key : {key[255:128], 128'h0};
         rc_in   = 8'h01;
         half_in = 1'b0;
      end else if (cmd.kinit) begin
         key_in  = fwd_key;
         rc_in   = fwd_rc;
         half_in = key_size ? ~half_ff : 1'b0;
      end else if (cmd.load) begin
         state_in = block_in ^ rk_cur;
      end else if (cmd.run || cmd.last) begin
         if (!decrypt) begin
            key_in  = fwd_key;
            rc_in   = fwd_rc;
            half_in = key_size ? ~half_ff : 1'b0;
            state_in = cmd.last ? enc_fin : enc_mid;
         end else begin
            key_in  = rev_key;
            rc_in   = rev_rc;
            half_in = key_size ? ~half_ff : 1'b0;
            state_in = cmd.last ? dec_fin : dec_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      rc_ff    <= rc_in;
      half_ff  <= half_in;
      state_ff <= state_in;
   end

   assign block_out = state_ff;

endmodule

### design/aes_control.sv
module aes_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 key_size,
   input  logic                 decrypt,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output aes_pkg::aes_cmd_type cmd
);
   import aes_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEY  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] rounds;

   assign rounds   = key_size ? 4'd14 : 4'd10;
   assign in_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.start_rev = 1'b1;
               cnt_in = 4'd0;
               state_in = decrypt ? ST_KEY : ST_RUN;
            end
         end
         ST_KEY: begin
            // walk forward to the final round key (rounds steps for 128, rounds-1 for 256)
            cmd.kinit = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == (key_size ? rounds - 4'd2 : rounds - 4'd1)) begin
               cnt_in = 4'd0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff == 4'd0) cmd.load = 1'b1;
            else if (cnt_ff == rounds) cmd.last = 1'b1;
            else cmd.run = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == rounds) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### design/aes_ecb_block_cipher.sv
// The result is held in the datapath state and offered once the final round is applied.
// Decrypt first walks the key schedule forward to the final round key.
// One block in flight: the next transfer is taken only once the result has been
// taken and the control has returned to idle.
// Synchronous active-high reset clears control state and configuration registers to zero.
module aes_ecb_block_cipher (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // block_hi[63:0], block_lo[127:64]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // out_hi[63:0], out_lo[127:64]
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [aes_pkg::IndexWidth-1:0] csr_index,
   input  logic [aes_pkg::WordWidth-1:0]  csr_data
);
   import aes_pkg::*;

   logic [WordWidth-1:0] key0_ff, key1_ff, key2_ff, key3_ff;
   logic ksize_ff, dir_ff;
   aes_cmd_type cmd;
   logic [BlockWidth-1:0] result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0; key3_ff <= '0;
         ksize_ff <= 1'b0; dir_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_KEY0:  key0_ff <= csr_data;
            REG_KEY1:  key1_ff <= csr_data;
            REG_KEY2:  key2_ff <= csr_data;
            REG_KEY3:  key3_ff <= csr_data;
            REG_KSIZE: ksize_ff <= csr_data[0];
            REG_DIR:   dir_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   aes_control u_ctrl (
      .clock(clock), .reset(reset), .key_size(ksize_ff), .decrypt(dir_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd(cmd)
   );

   // hold the accepted block until the load cycle
   logic [BlockWidth-1:0] blk_ff, blk_in;
   assign blk_in = (req_tvalid && req_tready) ? {req_tdata[63:0], req_tdata[127:64]} : blk_ff;
   always_ff @(posedge clock) blk_ff <= blk_in;

   aes_datapath u_dp (
      .clock(clock), .cmd(cmd), .decrypt(dir_ff), .key_size(ksize_ff),
      .key({key0_ff, key1_ff, key2_ff, key3_ff}),
      .block_in(blk_ff), .block_out(result)
   );

   assign rsp_tdata = {result[63:0], result[127:64]};

endmodule
